// File: rtl/depth_map_to_intensity_assert.svh
// Assertion macros for the depth_map_to_intensity RTL.
// Depends on nothing; included by depth_map_to_intensity, which checks its own logic.
`ifndef DEPTH_MAP_TO_INTENSITY_ASSERT_SVH
`define DEPTH_MAP_TO_INTENSITY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define DMTI_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define DMTI_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dmti_pkg.sv
// Shared types and constants for the depth-to-intensity block.
// No dependencies; imported by dmti_div, depth_map_to_intensity and the bench.
`default_nettype none

package dmti_pkg;

    // Result grey level
    localparam int INTENS_W = 8;
    localparam logic [INTENS_W-1:0] INTENS_MAX  = '1;
    localparam logic [INTENS_W-1:0] INTENS_ZERO = '0;

    // Quotient bit counter
    localparam int CNT_W = $clog2(INTENS_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(INTENS_W - 1);

    // Pass selector codes
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_MAP     = 1'b1;

    // Input sideband layout
    localparam int TUSER_W  = 3;
    localparam int TU_FUNC  = 0;
    localparam int TU_EMPTY = 1;
    localparam int TU_START = 2;

    // Divider status toward the controller
    typedef struct packed {
        logic                done;
        logic [INTENS_W-1:0] quot;
    } dmti_div_res_t;

endpackage

`default_nettype wire

// File: rtl/dmti_div.sv
// Bit-serial restoring divider: quot = floor(255 * numer / denom), numer < denom.
// Depends on dmti_pkg. One quotient bit per cycle after the D_PREP setup state.
`default_nettype none

module dmti_div
    import dmti_pkg::*;
#(
    parameter int DEPTH_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DEPTH_BITS-1:0] numer,
    input  wire logic [DEPTH_BITS-1:0] denom,
    output dmti_div_res_t              res
);

    typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN} dstate_t;

    dstate_t                 state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [DEPTH_BITS-1:0]   rem_reg, rem_next;
    logic [DEPTH_BITS-1:0]   den_reg, den_next;
    logic [INTENS_W-1:0]     low_reg, low_next;
    logic [INTENS_W-1:0]     quot_reg, quot_next;

    logic [DEPTH_BITS+INTENS_W-1:0] prod;
    logic [DEPTH_BITS:0]            trial;
    logic [DEPTH_BITS:0]            diff;

    // 255*n = 256*n - n; the upper part stays below denom
    assign prod  = {rem_reg, INTENS_ZERO} - {INTENS_ZERO, rem_reg};
    // Bring down the next dividend bit and try the subtraction
    assign trial = {rem_reg, low_reg[INTENS_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        den_next   = den_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    rem_next   = numer;
                    den_next   = denom;
                    state_next = D_PREP;
                end
            end
            D_PREP: begin
                rem_next   = prod[DEPTH_BITS+INTENS_W-1:INTENS_W];
                low_next   = prod[INTENS_W-1:0];
                cnt_next   = '0;
                state_next = D_RUN;
            end
            D_RUN: begin
                if (!diff[DEPTH_BITS]) begin
                    rem_next  = diff[DEPTH_BITS-1:0];
                    quot_next = {quot_reg[INTENS_W-2:0], 1'b1};
                end else begin
                    rem_next  = trial[DEPTH_BITS-1:0];
                    quot_next = {quot_reg[INTENS_W-2:0], 1'b0};
                end
                low_next = {low_reg[INTENS_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    // Hold state, counter and datapath shift registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

`default_nettype wire

// File: rtl/depth_map_to_intensity.sv
// Depth buffer to 8-bit grey level: min/max measure pass and scaling map pass.
// Depends on dmti_pkg, dmti_div and depth_map_to_intensity_assert.svh.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with depth in s_tdata and
//   {frame_start, empty_req, func} in s_tuser. A measure item (func 0)
//   updates the running min and max in the cycle it is accepted and gives
//   no result; the block is ready again on the next cycle. A map item
//   (func 1) gives one intensity on m_tvalid/m_tready.
//   Map item path: a range-check state (ST_SETUP), then, when the scaled
//   division runs, the divider forms 255*n (D_PREP) and finds the eight
//   quotient bits (D_RUN), the controller takes the quotient (ST_DIV) and
//   the handoff state (ST_WRITE) loads the output register; an empty or
//   out-of-range pixel or a flat range goes from ST_SETUP to the handoff.
//   One item is in flight at a time and the block is ready again the
//   cycle after the handoff.
//   The finished intensity waits in an output register; when the receiver
//   stalls, the next item is still taken and computed, and it waits in
//   the handoff state until the output register frees.
//   Reset (aresetn low, synchronous) empties the output, clears the seen
//   flag and sets min to the largest and max to the most negative depth.
`default_nettype none
`include "depth_map_to_intensity_assert.svh"

module depth_map_to_intensity
    import dmti_pkg::*;
#(
    parameter int DEPTH_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // s_tdata: depth (bits DEPTH_BITS-1:0), zero padding above
    input  wire logic [((DEPTH_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: func (bit 0), empty_req (bit 1), frame_start (bit 2)
    input  wire logic [TUSER_W-1:0]            s_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: intensity (bits 7:0)
    output      logic [INTENS_W-1:0]           m_tdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_DIV, ST_WRITE} state_t;

    state_t                state_reg, state_next;
    logic [DEPTH_BITS-1:0] bd_reg, bd_next;
    logic                  empty_reg, empty_next;
    logic [DEPTH_BITS-1:0] lo_b_reg, lo_b_next;
    logic [DEPTH_BITS-1:0] hi_b_reg, hi_b_next;
    logic                  seen_reg, seen_next;
    logic [INTENS_W-1:0]   res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    logic [INTENS_W-1:0]   m_data_reg, m_data_next;

    logic                  in_acc;
    logic                  meas_acc, map_acc;
    logic                  write_stall;
    logic [DEPTH_BITS-1:0] in_bd;
    logic [DEPTH_BITS-1:0] lo_base, hi_base;
    logic                  seen_base;
    logic                  map_ok, map_over;
    logic [DEPTH_BITS-1:0] num, den;
    logic                  div_start;
    dmti_div_res_t         div_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign meas_acc = in_acc && (s_tuser[TU_FUNC] == FUNC_MEASURE);
    assign map_acc  = in_acc && (s_tuser[TU_FUNC] == FUNC_MAP);
    assign write_stall = (state_reg == ST_WRITE) && m_valid_reg && !m_tready;

    // Offset-binary depth: signed order becomes unsigned order
    assign in_bd = {~s_tdata[DEPTH_BITS-1], s_tdata[DEPTH_BITS-2:0]};

    // Frame start on a measure item clears the running range before this item is used
    assign lo_base   = s_tuser[TU_START] ? '1   : lo_b_reg;
    assign hi_base   = s_tuser[TU_START] ? '0   : hi_b_reg;
    assign seen_base = s_tuser[TU_START] ? 1'b0 : seen_reg;

    // Map setup: offsets from the minimum and range checks
    assign num      = bd_reg - lo_b_reg;
    assign den      = hi_b_reg - lo_b_reg;
    assign map_ok   = !empty_reg && seen_reg && (hi_b_reg > lo_b_reg) && (bd_reg >= lo_b_reg);
    assign map_over = (bd_reg >= hi_b_reg);
    assign div_start = (state_reg == ST_SETUP) && map_ok && !map_over;

    dmti_div #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (num),
        .denom   (den),
        .res     (div_res)
    );

    always_comb begin
        state_next   = state_reg;
        bd_next      = bd_reg;
        empty_next   = empty_reg;
        lo_b_next    = lo_b_reg;
        hi_b_next    = hi_b_reg;
        seen_next    = seen_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the output item once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser[TU_FUNC] == FUNC_MEASURE) begin
                        // Update the range in the accept cycle
                        lo_b_next = lo_base;
                        hi_b_next = hi_base;
                        seen_next = seen_base;
                        if (!s_tuser[TU_EMPTY]) begin
                            if (in_bd < lo_base) begin
                                lo_b_next = in_bd;
                            end
                            if (in_bd > hi_base) begin
                                hi_b_next = in_bd;
                            end
                            seen_next = 1'b1;
                        end
                    end else begin
                        bd_next    = in_bd;
                        empty_next = s_tuser[TU_EMPTY];
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                if (!map_ok) begin
                    res_next   = INTENS_ZERO;
                    state_next = ST_WRITE;
                end else if (map_over) begin
                    res_next   = INTENS_MAX;
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    res_next   = div_res.quot;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state, range and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lo_b_reg    <= '1;
            hi_b_reg    <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lo_b_reg    <= lo_b_next;
            hi_b_reg    <= hi_b_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
        bd_reg     <= bd_next;
        empty_reg  <= empty_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Measure items finish in their accept cycle
    `DMTI_ASSERT_NEXT(a_measure_idle, aclk, aresetn, meas_acc, s_tready, "measure left busy")
    // Map items occupy the block
    `DMTI_ASSERT_NEXT(a_map_busy, aclk, aresetn, map_acc, !s_tready, "map did not start")
    // Once a finite depth is seen, min never exceeds max
    `DMTI_ASSERT_NOW(a_range_order, aclk, aresetn, seen_reg, lo_b_reg <= hi_b_reg, "range inverted")
    // Divider only reports while the controller waits for it
    `DMTI_ASSERT_NOW(a_div_done_state, aclk, aresetn, div_res.done, state_reg == ST_DIV, "stray done")
    // A pending result is never overwritten
    `DMTI_ASSERT_NEXT(a_hold_result, aclk, aresetn, write_stall, state_reg == ST_WRITE, "handoff overran")

endmodule

`default_nettype wire

// File: bench/depth_map_to_intensity_tb.sv
// Self-checking bench for depth_map_to_intensity: measure/map passes over pixel streams.
// Depends on dmti_pkg and the depth_map_to_intensity RTL; predicts each grey level
// in-bench and compares every result item in order.
`timescale 1ns / 100ps

module depth_map_to_intensity_tb
    import dmti_pkg::*;
();

    localparam int DEPTH_W    = 32;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 40;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DEPTH_W-1:0]   s_tdata  = '0;
    logic [TUSER_W-1:0]   s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [INTENS_W-1:0]  m_tdata;

    // Predictor state: running extremes of drawn depths
    logic signed [DEPTH_W-1:0] depth_lo;
    logic signed [DEPTH_W-1:0] depth_hi;
    logic                      seen_drawn;

    logic [INTENS_W-1:0] intens_q[$];
    int errors        = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles   = 0;

    depth_map_to_intensity #(.DEPTH_BITS(DEPTH_W)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Update extremes on a measure item, queue the grey level for a map item
    function automatic void predict_pixel(input logic fn, input logic [DEPTH_W-1:0] raw,
                                          input logic emp, input logic st);
        logic signed [DEPTH_W-1:0] d;
        longint span;
        longint offs;
        logic [INTENS_W-1:0] level;
        d = raw;
        if (fn == FUNC_MEASURE) begin
            if (st) begin
                depth_lo   = {1'b0, {(DEPTH_W-1){1'b1}}};
                depth_hi   = {1'b1, {(DEPTH_W-1){1'b0}}};
                seen_drawn = 1'b0;
            end
            if (!emp) begin
                if (d < depth_lo) depth_lo = d;
                if (d > depth_hi) depth_hi = d;
                seen_drawn = 1'b1;
            end
        end else begin
            level = INTENS_ZERO;
            if (!emp && seen_drawn && depth_hi > depth_lo && d >= depth_lo) begin
                span = longint'(depth_hi) - longint'(depth_lo);
                offs = longint'(d) - longint'(depth_lo);
                if (offs >= span) level = INTENS_MAX;
                else level = INTENS_W'((offs * 255) / span);
            end
            intens_q.push_back(level);
        end
    endfunction

    // Offer one item, with random idle cycles first, and hold it until taken
    task automatic send_pixel(input logic fn, input logic [DEPTH_W-1:0] d,
                              input logic emp, input logic st);
        logic [TUSER_W-1:0] side;
        side = '0;
        side[TU_FUNC]  = fn;
        side[TU_EMPTY] = emp;
        side[TU_START] = st;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= side;
        do @(posedge aclk); while (!s_tready);
        predict_pixel(fn, d, emp, st);
        items_sent++;
    endtask

    // Stop offering items and hold until every queued grey level is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (intens_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver stalls at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        logic [INTENS_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (intens_q.size() == 0) begin
                report_mismatch($sformatf("unexpected intensity %0d", m_tdata));
            end else begin
                want = intens_q.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("intensity %0d, expected %0d", m_tdata, want));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("depth_map_to_intensity_tb failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Map before anything finite was measured: all zero
    task automatic test_nothing_measured();
        send_pixel(FUNC_MAP, 32'h0000_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h8000_0000, 1'b1, 1'b0);
        send_pixel(FUNC_MEASURE, 32'h0001_0000, 1'b1, 1'b1);
        send_pixel(FUNC_MAP, 32'h1234_5678, 1'b0, 1'b0);
    endtask

    // Widest possible range, empty pixels, frame start during map
    task automatic test_full_range();
        send_pixel(FUNC_MEASURE, 32'h8000_0000, 1'b0, 1'b1);
        send_pixel(FUNC_MEASURE, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_pixel(FUNC_MEASURE, 32'h0000_0000, 1'b1, 1'b0);
        send_pixel(FUNC_MAP, 32'h8000_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h0000_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_pixel(FUNC_MAP, 32'h4000_0000, 1'b0, 1'b1);
    endtask

    // Max equals min: every pixel maps to zero
    task automatic test_flat_range();
        send_pixel(FUNC_MEASURE, 32'h0001_0000, 1'b0, 1'b1);
        send_pixel(FUNC_MEASURE, 32'h0001_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h0001_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h0002_0000, 1'b0, 1'b0);
    endtask

    // Depths below min and above max clamp; one depth in between scales
    task automatic test_out_of_range();
        send_pixel(FUNC_MEASURE, 32'hFFFE_0000, 1'b0, 1'b1);
        send_pixel(FUNC_MEASURE, 32'h0003_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'hFFFB_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h0007_0000, 1'b0, 1'b0);
        send_pixel(FUNC_MAP, 32'h0000_8000, 1'b0, 1'b0);
    endtask

    // Random frames: measure run then map run, with some noise and broken frames
    task automatic test_random_frames(input int count, input int send_pct, input int recv_pct);
        int stop_at;
        int nmeas;
        int nmap;
        int mode;
        logic [DEPTH_W-1:0] base;
        logic [DEPTH_W-1:0] span;
        logic [DEPTH_W-1:0] d;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                // single noise item
                send_pixel(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end else begin
                base = $urandom;
                mode = $urandom_range(3);
                case (mode)
                    0: span = $urandom_range(16);
                    1: span = $urandom_range(32'hFFFF);
                    2: span = $urandom >> $urandom_range(31);
                    default: span = $urandom;
                endcase
                nmeas = $urandom_range(1, 8);
                for (int i = 0; i < nmeas; i++) begin
                    d = (mode == 3) ? $urandom : base + $urandom_range(span);
                    send_pixel(FUNC_MEASURE, d, $urandom_range(5) == 0,
                               (i == 0) && ($urandom_range(9) != 0));
                end
                nmap = $urandom_range(1, 8);
                for (int i = 0; i < nmap; i++) begin
                    if ($urandom_range(7) == 0) d = $urandom;
                    else if (mode == 3) d = $urandom;
                    else d = base + $urandom_range(span);
                    send_pixel(FUNC_MAP, d, $urandom_range(7) == 0, $urandom_range(7) == 0);
                end
            end
        end
    endtask

    initial begin
        depth_lo   = {1'b0, {(DEPTH_W-1){1'b1}}};
        depth_hi   = {1'b1, {(DEPTH_W-1){1'b0}}};
        seen_drawn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 6;
        recv_stall_pct = 56;
        test_nothing_measured();
        test_full_range();
        drain_results();
        test_flat_range();
        test_out_of_range();
        drain_results();

        test_random_frames(134, 6, 56);
        drain_results();
        test_random_frames(134, 56, 6);
        drain_results();
        test_random_frames(134, 0, 0);
        drain_results();

        repeat (TAIL_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("depth_map_to_intensity_tb passed");
        end else begin
            $display("depth_map_to_intensity_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/dmti_pkg.sv
rtl/dmti_div.sv
rtl/depth_map_to_intensity.sv
bench/depth_map_to_intensity_tb.sv
